// ===== design/alarm_annunciator_ack_cycle_defines.svh =====
// Assertion macros for the alarm annunciator.
// Depends on nothing; included by the files that carry assertions.
`ifndef ALARM_ANNUNCIATOR_ACK_CYCLE_DEFINES_SVH
`define ALARM_ANNUNCIATOR_ACK_CYCLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AAAC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define AAAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/aaac_pkg.sv =====
// Package for the alarm annunciator: state and result types, event codes,
// colour table and the pointer search. Depends on nothing.
package aaac_pkg;

   localparam int unsigned NTYPES = 9;

   localparam logic [3:0] PTR_END   = 4'd9;
   localparam logic [3:0] TYPE_NONE = 4'd8;

   localparam logic [2:0] KIND_RAISE     = 3'd0;
   localparam logic [2:0] KIND_CLEAR     = 3'd1;
   localparam logic [2:0] KIND_TICK      = 3'd2;
   localparam logic [2:0] KIND_ACK_REQ   = 3'd3;
   localparam logic [2:0] KIND_CLEAR_ALL = 3'd4;

   typedef logic [NTYPES-1:0] mask_type;

   typedef struct packed {
      mask_type   present;
      mask_type   acked;
      mask_type   active;
      logic [3:0] ptr;
      logic       ack_pending;
   } state_type;

   typedef struct packed {
      logic       clear_all;
      mask_type   remove_mask;
      logic [2:0] add_type;
      logic       add_valid;
      logic       led_blue;
      logic       led_green;
      logic       led_red;
      logic       led_valid;
   } result_type;

   // Colour of an alarm type as {red, green, blue}.
   function automatic logic [2:0] colour(input logic [3:0] t);
      logic [2:0] rgb;
      unique case (t)
         4'd0:    rgb = 3'b010;
         4'd1:    rgb = 3'b111;
         4'd2:    rgb = 3'b101;
         4'd3:    rgb = 3'b110;
         4'd4:    rgb = 3'b100;
         4'd5:    rgb = 3'b001;
         4'd6:    rgb = 3'b001;
         4'd7:    rgb = 3'b011;
         default: rgb = 3'b000;
      endcase
      return rgb;
   endfunction

   // Lowest set bit of the mask at or above start, or the end mark.
   function automatic logic [3:0] first_from(input mask_type mask, input logic [3:0] start);
      logic [3:0] found;
      found = PTR_END;
      for (int i = NTYPES - 1; i >= 0; i--) begin
         if (mask[i] && (4'(i) >= start)) begin
            found = 4'(i);
         end
      end
      return found;
   endfunction

   // One bit of a mask at a four-bit position; positions past the mask read zero.
   function automatic logic bit_at(input mask_type mask, input logic [3:0] idx);
      mask_type shifted;
      shifted = mask >> idx;
      return shifted[0];
   endfunction

endpackage

// ===== design/alarm_annunciator_ack_cycle.sv =====
// Top level of the alarm annunciator: stream ports, input and result
// registers, alarm state. Depends on aaac_pkg, aaac_step and the defines header.
//
//   Channel   Direction  Handshake            Payload
//   req       in         req_tvalid/tready    tuser: kind; tdata: alarm_type
//   rsp       out        rsp_tvalid/tready    tdata: result fields
//   csr       in         csr_valid/ready      csr_data: keep_notifying_after_ack
//
// One event beat is taken every cycle while req_tready is high; each gives exactly
// one result beat: it sits in the input register, then makes one pass through the step
// logic into the result register, which also updates the alarm state.
// Reset is synchronous and active high; it empties both registers, returns
// the alarm state to no alarms with the pointer at the end mark and clears the
// configuration bit. A stalled result holds the result register; an event
// already in the input register then waits there, and req_tready falls only
// once both registers are full.

`include "alarm_annunciator_ack_cycle_defines.svh"

module alarm_annunciator_ack_cycle (
   input  logic        clock,
   input  logic        reset,
   // Event beats.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] alarm_type, [7:4] zero
   input  logic [2:0]  req_tuser,   // [2:0] kind
   // Result beats.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] led_valid, [1] led_red, [2] led_green, [3] led_blue,
   // [4] notice_add_valid, [7:5] notice_add_type, [16:8] notice_remove_mask,
   // [17] notice_clear_all, [23:18] zero
   output logic [23:0] rsp_tdata,
   // Configuration writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);
   import aaac_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [2:0] in_kind_ff;
   logic [3:0] in_type_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff;
   state_type  state_ff, state_in;
   result_type step_res;
   logic       keep_ff;
   logic       out_free;
   logic       advance;
   logic       req_accept;

   // The result register frees up when it is empty or being taken this cycle.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // The step logic sees the event in the input register and the state as it
   // stands; its outcome is committed only when the event moves on.
   aaac_step u_step (
      .cur         (state_ff),
      .keep_notify (keep_ff),
      .kind        (in_kind_ff),
      .alarm_type  (in_type_ff),
      .nxt         (state_in),
      .res         (step_res)
   );

   always_comb begin
      in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         keep_ff              <= 1'b0;
         state_ff.present     <= '0;
         state_ff.acked       <= '0;
         state_ff.active      <= '0;
         state_ff.ptr         <= PTR_END;
         state_ff.ack_pending <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            keep_ff <= csr_data;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_kind_ff <= req_tuser;
         in_type_ff <= req_tdata[3:0];
      end
      if (advance) begin
         out_data_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_data_ff};

   // An event waiting with the result register empty always moves on.
   `AAAC_ASSERT_NEXT(a_in_moves_on, clock, reset, in_valid_ff && !out_valid_ff, out_valid_ff, "event stuck in input register")
   // Every accepted beat lands in the input register.
   `AAAC_ASSERT_NEXT(a_accept_lands, clock, reset, req_accept, in_valid_ff, "accepted beat lost")
   // Active alarms are always present and unacknowledged; acknowledged ones are present.
   `AAAC_ASSERT_NOW(a_state_consistent, clock, reset, 1'b1, ((state_ff.active & ~(state_ff.present & ~state_ff.acked)) == '0) && ((state_ff.acked & ~state_ff.present) == '0), "alarm bit sets inconsistent")

endmodule

// ===== design/aaac_step.sv =====
// Next-state and result logic of the alarm annunciator for one event.
// Depends on aaac_pkg.
module aaac_step (
   input  aaac_pkg::state_type  cur,
   input  logic                 keep_notify,
   input  logic [2:0]           kind,
   input  logic [3:0]           alarm_type,
   output aaac_pkg::state_type  nxt,
   output aaac_pkg::result_type res
);
   import aaac_pkg::*;

   always_comb begin
      mask_type   sel;
      mask_type   newly;
      mask_type   act_t;
      mask_type   act_c;
      logic [3:0] ptr_t;
      logic [3:0] p;
      logic [2:0] rgb;
      logic       acked;

      nxt   = cur;
      res   = '0;
      sel   = mask_type'(1) << alarm_type;
      newly = cur.present & ~cur.acked;
      act_t = cur.active;
      act_c = cur.active & ~sel;
      ptr_t = cur.ptr;
      p     = '0;
      rgb   = '0;
      acked = |(cur.acked & sel);

      unique case (kind)
         KIND_RAISE: begin
            if (alarm_type < TYPE_NONE) begin
               nxt.present = cur.present | sel;
               if (!acked || keep_notify) begin
                  res.add_valid = 1'b1;
                  res.add_type  = alarm_type[2:0];
               end
               if (!acked) begin
                  nxt.active = cur.active | sel;
               end
            end
         end
         KIND_CLEAR: begin
            if (alarm_type < 4'(NTYPES)) begin
               nxt.present     = cur.present & ~sel;
               nxt.acked       = cur.acked & ~sel;
               nxt.active      = act_c;
               res.remove_mask = sel;
               if ((cur.ptr == alarm_type) || (cur.ptr == PTR_END)) begin
                  nxt.ptr = first_from(act_c, 4'd0);
               end
            end
         end
         KIND_TICK: begin
            if (cur.ack_pending) begin
               nxt.acked       = cur.acked | newly;
               res.remove_mask = keep_notify ? '0 : newly;
               act_t           = cur.active & ~newly;
               ptr_t           = first_from(act_t, 4'd0);
               nxt.ack_pending = 1'b0;
            end
            nxt.active    = act_t;
            res.led_valid = 1'b1;
            if (act_t == '0) begin
               rgb     = colour(4'd0);
               nxt.ptr = ptr_t;
            end else begin
               p       = ((ptr_t < 4'(NTYPES)) && bit_at(act_t, ptr_t))
                         ? ptr_t : first_from(act_t, 4'd0);
               rgb     = colour(p);
               nxt.ptr = first_from(act_t, p + 4'd1);
            end
            res.led_red   = rgb[2];
            res.led_green = rgb[1];
            res.led_blue  = rgb[0];
         end
         KIND_ACK_REQ: begin
            nxt.ack_pending = 1'b1;
         end
         KIND_CLEAR_ALL: begin
            nxt.present   = '0;
            nxt.acked     = '0;
            nxt.active    = '0;
            nxt.ptr       = PTR_END;
            res.clear_all = 1'b1;
            res.led_valid = 1'b1;
         end
         default: begin
            // Unused event codes change nothing and give an all-zero result.
            nxt = cur;
         end
      endcase
   end

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the alarm annunciator (alarm_annunciator_ack_cycle).
// It predicts every result beat from its own model of the alarm state and
// checks it field by field. Depends on aaac_pkg and the design top level only.
`timescale 1ns / 100ps

module tb;
   import aaac_pkg::*;

   // Kinds 5 to 7 carry no meaning and must leave the state untouched.
   localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

   localparam int RESET_CYCLES  = 12;
   // Two register stages sit between an event and its result, so this quiet stretch
   // is plenty before a configuration write or the end of the run.
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 150;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PRINT_LIMIT   = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [3:0] alarm_type, [7:4] zero
   logic [2:0]  req_tuser = '0;   // [2:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [0] led_valid, [1] led_red, [2] led_green, [3] led_blue,
   // [4] notice_add_valid, [7:5] notice_add_type, [16:8] notice_remove_mask,
   // [17] notice_clear_all, [23:18] zero
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data = 1'b0;

   alarm_annunciator_ack_cycle dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin : clock_gen
      forever #2 clock = ~clock;
   end

   // Our own copy of the alarm state and of the configuration bit.
   mask_type   alarms_present = '0;
   mask_type   alarms_acked   = '0;
   mask_type   alarms_active  = '0;
   logic [3:0] display_next   = PTR_END;
   logic       ack_requested  = 1'b0;
   logic       keep_notifying = 1'b0;

   result_type expected_annunciations[$];

   int mismatch_count = 0;
   int results_seen   = 0;
   int send_idle_pct  = 0;
   int rsp_idle_pct   = 0;
   int hold_requests  = 0;
   int cycle_count    = 0;

   // Lowest active type at or above a position, or the end mark.
   function automatic logic [3:0] scan_up(input mask_type mask, input int start);
      for (int i = start; i < NTYPES; i++) begin
         if (mask[i]) return 4'(i);
      end
      return PTR_END;
   endfunction

   // Lamp colour of a type as {red, green, blue}.
   function automatic logic [2:0] lamp_rgb(input logic [3:0] t);
      case (t)
         4'd0:    return 3'b010;
         4'd1:    return 3'b111;
         4'd2:    return 3'b101;
         4'd3:    return 3'b110;
         4'd4:    return 3'b100;
         4'd5:    return 3'b001;
         4'd6:    return 3'b001;
         4'd7:    return 3'b011;
         default: return 3'b000;
      endcase
   endfunction

   // Applies one event to the predicted state and returns the result it gives.
   function automatic result_type annunciate(input logic [2:0] kind, input logic [3:0] t);
      result_type r;
      mask_type   type_bit;
      mask_type   newly;
      logic [3:0] shown;
      logic [2:0] rgb;
      r        = '0;
      rgb      = 3'b000;
      type_bit = (t < NTYPES) ? (mask_type'(1) << t) : '0;
      case (kind)
         KIND_RAISE: begin
            // Type none and anything above it raise nothing.
            if (t < TYPE_NONE) begin
               if ((alarms_acked & type_bit) == '0 || keep_notifying) begin
                  r.add_valid = 1'b1;
                  r.add_type  = t[2:0];
               end
               if ((alarms_acked & type_bit) == '0) alarms_active |= type_bit;
               alarms_present |= type_bit;
            end
         end
         KIND_CLEAR: begin
            if (t < NTYPES) begin
               alarms_present &= ~type_bit;
               alarms_acked   &= ~type_bit;
               alarms_active  &= ~type_bit;
               r.remove_mask   = type_bit;
               // The pointer is repaired when it named the cleared type or had run off.
               if (display_next == t || display_next == PTR_END) begin
                  display_next = scan_up(alarms_active, 0);
               end
            end
         end
         KIND_TICK: begin
            if (ack_requested) begin
               newly          = alarms_present & ~alarms_acked;
               alarms_acked  |= newly;
               alarms_active &= ~newly;
               if (!keep_notifying) r.remove_mask = newly;
               display_next  = scan_up(alarms_active, 0);
               ack_requested = 1'b0;
            end
            r.led_valid = 1'b1;
            if (alarms_active == '0) begin
               rgb = lamp_rgb(4'd0);
            end else begin
               shown = display_next;
               if (shown >= NTYPES) begin
                  shown = scan_up(alarms_active, 0);
               end else if (!alarms_active[shown]) begin
                  shown = scan_up(alarms_active, 0);
               end
               rgb          = lamp_rgb(shown);
               display_next = scan_up(alarms_active, int'(shown) + 1);
            end
         end
         KIND_ACK_REQ: begin
            ack_requested = 1'b1;
         end
         KIND_CLEAR_ALL: begin
            // A pending acknowledge survives a clear all.
            alarms_present = '0;
            alarms_acked   = '0;
            alarms_active  = '0;
            display_next   = PTR_END;
            r.clear_all    = 1'b1;
            r.led_valid    = 1'b1;
         end
         default: ;
      endcase
      r.led_red   = rgb[2];
      r.led_green = rgb[1];
      r.led_blue  = rgb[0];
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int unsigned got,
                                  input int unsigned want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("%0t: result %0d, %s: got 0x%0h, expected 0x%0h",
                  $realtime, results_seen, field, got, want);
      end
   endtask

   // Offers one event beat, with random idle cycles ahead of it, and records
   // its prediction at the edge where it is taken. The valid is left high so
   // that back-to-back beats never drop it within a time step.
   task automatic post_event(input logic [2:0] kind, input logic [3:0] atype);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0000, atype};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_annunciations.push_back(annunciate(kind, atype));
   endtask

   // Stops offering and waits until every predicted result has been checked.
   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      while (expected_annunciations.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_keep_notifying(input logic value);
      wait_until_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid      <= 1'b0;
      keep_notifying  = value;
   endtask

   // Mostly well-formed alarm traffic; a few percent of beats are events that
   // the block must ignore, covering the upper type and kind codes.
   task automatic pick_random_event(output logic [2:0] kind, output logic [3:0] atype);
      int unsigned roll;
      roll  = $urandom_range(99);
      atype = 4'($urandom_range(7));
      if (roll < 32) begin
         kind = KIND_RAISE;
      end else if (roll < 50) begin
         kind = KIND_CLEAR;
         if ($urandom_range(9) == 0) atype = TYPE_NONE;
      end else if (roll < 80) begin
         kind  = KIND_TICK;
         atype = 4'($urandom_range(15));
      end else if (roll < 89) begin
         kind  = KIND_ACK_REQ;
         atype = 4'($urandom_range(15));
      end else if (roll < 92) begin
         kind = KIND_CLEAR_ALL;
      end else if (roll < 94) begin
         kind  = KIND_RAISE;
         atype = 4'($urandom_range(15, 8));
      end else if (roll < 96) begin
         kind  = KIND_CLEAR;
         atype = 4'($urandom_range(15, 9));
      end else begin
         kind  = 3'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
         atype = 4'($urandom_range(15));
      end
   endtask

   // Every special case in turn: an empty display, type none, out-of-range
   // types, spare kinds, the round robin wrap, pointer repair on clear, the
   // acknowledge cycle with and without continued notices, and a pending
   // acknowledge that outlives a clear all.
   task automatic test_directed_events();
      send_idle_pct = 20;
      rsp_idle_pct  = 20;
      write_keep_notifying(1'b0);
      post_event(KIND_TICK, 4'd0);
      post_event(KIND_RAISE, 4'd0);
      post_event(KIND_RAISE, 4'd7);
      post_event(KIND_RAISE, TYPE_NONE);
      post_event(KIND_RAISE, 4'd15);
      post_event(KIND_SPARE_LAST, 4'd15);
      post_event(KIND_TICK, 4'd0);
      post_event(KIND_TICK, 4'd0);
      post_event(KIND_TICK, 4'd0);
      post_event(KIND_CLEAR, 4'd7);
      post_event(KIND_CLEAR, TYPE_NONE);
      post_event(KIND_CLEAR, 4'd9);
      post_event(KIND_RAISE, 4'd5);
      post_event(KIND_ACK_REQ, 4'd0);
      post_event(KIND_TICK, 4'd0);
      post_event(KIND_RAISE, 4'd5);
      post_event(KIND_TICK, 4'd0);
      post_event(KIND_ACK_REQ, 4'd0);
      post_event(KIND_CLEAR_ALL, 4'd0);
      post_event(KIND_TICK, 4'd0);
      write_keep_notifying(1'b1);
      post_event(KIND_RAISE, 4'd3);
      post_event(KIND_ACK_REQ, 4'd0);
      post_event(KIND_TICK, 4'd0);
      post_event(KIND_RAISE, 4'd3);
      post_event(KIND_TICK, 4'd0);
      post_event(KIND_CLEAR, 4'd3);
      post_event(KIND_SPARE_FIRST, 4'd0);
   endtask

   // Random traffic at the given idle rates, half under each setting of the
   // configuration bit. Ignored events do not count toward the total.
   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int events, input logic first_keep);
      logic [2:0] kind;
      logic [3:0] atype;
      int         counted;
      send_idle_pct = sender_pct;
      rsp_idle_pct  = receiver_pct;
      for (int half = 0; half < 2; half++) begin
         write_keep_notifying(first_keep ^ half[0]);
         counted = 0;
         while (counted < events / 2) begin
            pick_random_event(kind, atype);
            post_event(kind, atype);
            if (!(kind > KIND_CLEAR_ALL || (kind == KIND_RAISE && atype >= TYPE_NONE) ||
                  (kind == KIND_CLEAR && atype > TYPE_NONE))) begin
               counted++;
            end
         end
      end
   endtask

   // The receiver holds off for a long stretch while events keep coming, so
   // both registers fill and the input stalls; then the sender pauses until
   // every result is home.
   task automatic test_result_backpressure();
      logic [2:0] kind;
      logic [3:0] atype;
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_requests++;
      repeat (40) begin
         pick_random_event(kind, atype);
         post_event(kind, atype);
      end
      wait_until_drained();
   endtask

   // Result side: random stalls, and a long hold whenever one is requested.
   always @(posedge clock) begin : result_sink
      static int hold_left    = 0;
      static int holds_served = 0;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Every accepted result beat is checked against the oldest prediction.
   always @(posedge clock) begin : check_annunciation
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         got = result_type'(rsp_tdata[17:0]);
         if (expected_annunciations.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata, 0);
         end else begin
            want = expected_annunciations.pop_front();
            if (got.led_valid != want.led_valid)
               report_mismatch("led_valid", got.led_valid, want.led_valid);
            if (got.led_red != want.led_red)
               report_mismatch("led_red", got.led_red, want.led_red);
            if (got.led_green != want.led_green)
               report_mismatch("led_green", got.led_green, want.led_green);
            if (got.led_blue != want.led_blue)
               report_mismatch("led_blue", got.led_blue, want.led_blue);
            if (got.add_valid != want.add_valid)
               report_mismatch("notice_add_valid", got.add_valid, want.add_valid);
            if (got.add_type != want.add_type)
               report_mismatch("notice_add_type", got.add_type, want.add_type);
            if (got.remove_mask != want.remove_mask)
               report_mismatch("notice_remove_mask", got.remove_mask, want.remove_mask);
            if (got.clear_all != want.clear_all)
               report_mismatch("notice_clear_all", got.clear_all, want.clear_all);
            if (rsp_tdata[23:18] !== 6'd0)
               report_mismatch("padding", rsp_tdata[23:18], 0);
         end
      end
   end

   // A hung handshake ends the run here.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("alarm_annunciator_ack_cycle regression: fail");
      $finish;
   end

   initial begin : regression
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_events();
      test_random_traffic(38, 57, 140, 1'b0);
      test_random_traffic(57, 38, 140, 1'b1);
      test_random_traffic(0, 0, 140, 1'b0);
      test_result_backpressure();
      wait_until_drained();
      if (mismatch_count == 0) begin
         $display("alarm_annunciator_ack_cycle regression: pass");
      end else begin
         $display("alarm_annunciator_ack_cycle regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/aaac_pkg.sv
design/aaac_step.sv
design/alarm_annunciator_ack_cycle.sv
verif/tb.sv
